[design/wlq_pkg.sv]
// Package for the waitlist queue: sizes, codes, entry type and name cleanup.
`default_nettype none

package wlq_pkg;

  localparam int DEPTH      = 16;
  localparam int NAME_BYTES = 20;

  localparam int NAME_FIELD_BYTES = 20;  // bytes carried by the three name fields
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_LIST   = 2'd2,
    OP_FIND   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_EMPTY    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT
  } state_e;

  typedef struct packed {
    logic [7:0]  size;
    logic [31:0] hi;
    logic [63:0] mid;
    logic [63:0] lo;
  } entry_t;

  // Clear every byte from the first zero byte (or NAME_BYTES) onward.
  function automatic logic [8*NAME_FIELD_BYTES-1:0] canon_name(
    input logic [63:0] lo,
    input logic [63:0] mid,
    input logic [31:0] hi
  );
    logic [8*NAME_FIELD_BYTES-1:0] src;
    logic [8*NAME_FIELD_BYTES-1:0] dst;
    logic                          alive;
    src   = {hi, mid, lo};
    dst   = '0;
    alive = 1'b1;
    for (int i = 0; i < NAME_FIELD_BYTES; i++) begin
      if (src[8*i +: 8] == 8'h00 || i >= NAME_BYTES) begin
        alive = 1'b0;
      end
      if (alive) begin
        dst[8*i +: 8] = src[8*i +: 8];
      end
    end
    return dst;
  endfunction

endpackage

`default_nettype wire

[design/waitlist_queue_search_remove.sv]
// Top level of the waitlist queue: command sequencer, storage and compare unit.
`default_nettype none

// Waitlist queue with search and remove.
// Command channel: a transaction is taken at a rising edge with start high and busy
// low. op_i picks add, cancel by size, list all or find by size; the name fields
// are used by add, group_size_i by add, cancel and find.
// Result channel: result_valid_o marks each result for exactly one cycle; the
// receiver cannot stall it. Every command ends with a result that has last_o set.
// List and find give one result per reported entry, oldest first.
// Timing: the sequencer walks the stored entries through one memory read port
// (registered read data) and one shared compare unit, one entry per cycle. Add
// with a duplicate and cancel stop at the first hit. Cancel then moves each later
// entry up one place, one entry per cycle. Results are registered and show in the
// cycle after they are decided; the last result shows in the first cycle with busy
// low, when the next command can be taken. Reset empties the queue (entry count
// zero); storage itself is not cleared and needs no clearing pass. No item is lost
// or reordered since nothing stalls.
module waitlist_queue_search_remove
  import wlq_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  op_i,
  input  wire logic [63:0] name_lo_i,
  input  wire logic [63:0] name_mid_i,
  input  wire logic [31:0] name_hi_i,
  input  wire logic [7:0]  group_size_i,
  output logic             result_valid_o,
  output logic [63:0]      out_name_lo_o,
  output logic [63:0]      out_name_mid_o,
  output logic [31:0]      out_name_hi_o,
  output logic [7:0]       out_size_o,
  output logic [2:0]       status_o,
  output logic             last_o
);

  // sequencer state
  state_e            state_q, state_d;
  op_e               op_q, op_d;
  entry_t            key_q, key_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;        // entries stored
  logic [CNT_W-1:0]  rd_idx_q, rd_idx_d;  // next read address
  logic              dv_q, dv_d;          // read data valid this cycle
  logic [ADDR_W-1:0] di_q, di_d;          // address of the data now at the read port
  logic              pend_v_q, pend_v_d;  // list/find: a hit waits to be reported
  entry_t            pend_q, pend_d;

  // result registers
  logic              res_v_q;
  entry_t            res_entry_q;
  status_e           res_status_q;
  logic              res_last_q;

  // storage and compare
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  entry_t            mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  entry_t            mem_rdata;
  logic              hit;

  // result request from the sequencer
  logic              emit;
  entry_t            emit_entry;
  status_e           emit_status;
  logic              emit_last;

  logic              issue;
  logic [8*NAME_FIELD_BYTES-1:0] canon;

  wlq_store u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  wlq_cmp u_cmp (
    .op_i    (op_q),
    .entry_i (mem_rdata),
    .key_i   (key_q),
    .hit_o   (hit)
  );

  assign canon = canon_name(name_lo_i, name_mid_i, name_hi_i);
  assign issue = (rd_idx_q < cnt_q);
  assign busy  = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      rd_idx_q <= '0;
      dv_q     <= 1'b0;
      pend_v_q <= 1'b0;
      res_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rd_idx_q <= rd_idx_d;
      dv_q     <= dv_d;
      pend_v_q <= pend_v_d;
      res_v_q  <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    key_q  <= key_d;
    di_q   <= di_d;
    pend_q <= pend_d;
    if (emit) begin
      res_entry_q  <= emit_entry;
      res_status_q <= emit_status;
      res_last_q   <= emit_last;
    end
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    key_d       = key_q;
    cnt_d       = cnt_q;
    rd_idx_d    = rd_idx_q;
    dv_d        = 1'b0;
    di_d        = di_q;
    pend_v_d    = pend_v_q;
    pend_d      = pend_q;
    mem_we      = 1'b0;
    mem_waddr   = cnt_q[ADDR_W-1:0];
    mem_wdata   = key_q;
    mem_raddr   = rd_idx_q[ADDR_W-1:0];
    emit        = 1'b0;
    emit_entry  = '0;
    emit_status = ST_OK;
    emit_last   = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d     = op_e'(op_i);
          key_d    = {group_size_i, canon};
          rd_idx_d = '0;
          pend_v_d = 1'b0;
          state_d  = S_SCAN;
        end
      end

      S_SCAN: begin
        if (issue) begin
          rd_idx_d = rd_idx_q + CNT_W'(1);
          dv_d     = 1'b1;
          di_d     = rd_idx_q[ADDR_W-1:0];
        end
        if (dv_q && hit) begin
          case (op_q) inside
            OP_ADD: begin
              emit        = 1'b1;
              emit_status = ST_DUP;
              dv_d        = 1'b0;
              state_d     = S_IDLE;
            end
            OP_CANCEL: begin
              // drop the read in flight, restart reading just past the hit
              dv_d     = 1'b0;
              rd_idx_d = CNT_W'(di_q) + CNT_W'(1);
              state_d  = S_SHIFT;
            end
            OP_LIST, OP_FIND: begin
              // a new hit proves the held one is not the final result
              if (pend_v_q) begin
                emit       = 1'b1;
                emit_entry = pend_q;
                emit_last  = 1'b0;
              end
              pend_v_d = 1'b1;
              pend_d   = mem_rdata;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end else if (!issue && !dv_q) begin
          // walk finished with nothing in flight
          emit    = 1'b1;
          state_d = S_IDLE;
          case (op_q) inside
            OP_ADD: begin
              if (cnt_q == CNT_W'(DEPTH)) begin
                emit_status = ST_FULL;
              end else begin
                mem_we = 1'b1;
                cnt_d  = cnt_q + CNT_W'(1);
              end
            end
            OP_CANCEL: begin
              emit_status = ST_NOTFOUND;
            end
            OP_LIST, OP_FIND: begin
              if (pend_v_q) begin
                emit_entry = pend_q;
              end else begin
                emit_status = ST_EMPTY;
              end
            end
            default: begin
              emit_status = ST_EMPTY;
            end
          endcase
        end
      end

      S_SHIFT: begin
        // read entry k, write it back at k-1 in the next cycle
        if (issue) begin
          rd_idx_d = rd_idx_q + CNT_W'(1);
          dv_d     = 1'b1;
          di_d     = rd_idx_q[ADDR_W-1:0];
        end
        if (dv_q) begin
          mem_we    = 1'b1;
          mem_waddr = di_q - ADDR_W'(1);
          mem_wdata = mem_rdata;
        end else if (!issue) begin
          cnt_d   = cnt_q - CNT_W'(1);
          emit    = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign result_valid_o = res_v_q;
  assign out_name_lo_o  = res_entry_q.lo;
  assign out_name_mid_o = res_entry_q.mid;
  assign out_name_hi_o  = res_entry_q.hi;
  assign out_size_o     = res_entry_q.size;
  assign status_o       = res_status_q;
  assign last_o         = res_last_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_end_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> (result_valid_o && last_o))
    else $error("command ended without a final result");

  a_mid_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_o) |-> busy)
    else $error("non-final result outside a command");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  a_shift_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |-> (cnt_q != '0))
    else $error("shift with empty queue");
`endif

endmodule

`default_nettype wire

[design/wlq_store.sv]
// Entry storage: one write port, one read port with registered read data.
`default_nettype none

module wlq_store
  import wlq_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire entry_t            wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output entry_t                 rdata_o
);

  entry_t mem [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[design/wlq_cmp.sv]
// Shared compare unit: matches one stored entry against the command key.
`default_nettype none

module wlq_cmp
  import wlq_pkg::*;
(
  input  wire op_e    op_i,
  input  wire entry_t entry_i,
  input  wire entry_t key_i,
  output logic        hit_o
);

  logic name_eq;
  logic size_eq;

  assign name_eq = (entry_i.lo == key_i.lo) && (entry_i.mid == key_i.mid) &&
                   (entry_i.hi == key_i.hi);
  assign size_eq = (entry_i.size == key_i.size);

  always_comb begin
    unique case (op_i)
      OP_ADD:    hit_o = name_eq;
      OP_CANCEL: hit_o = size_eq;
      OP_LIST:   hit_o = 1'b1;
      OP_FIND:   hit_o = size_eq;
      default:   hit_o = 1'b0;
    endcase
  end

endmodule

`default_nettype wire
